// File: src/nps_pkg.sv
package nps_pkg;

    localparam int COORD_W            = 16;
    localparam int MAG_W              = 16;
    localparam int SQ_W               = 2 * MAG_W;
    localparam int DIST_W             = 34;
    localparam int IDX_OUT_W          = 12;
    localparam int ACTION_W           = 2;
    localparam int DEFAULT_MAX_POINTS = 4096;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    // One stored or queried point, x in the lowest bits.
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    localparam int POINT_W = $bits(point_t);

    // Marks that travel with each point through the distance pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } tag_t;

endpackage

// File: src/nps_ram.sv
module nps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/nps_dist.sv
module nps_dist import nps_pkg::*; #(
    parameter int IDX_W = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tag_t              in_tag,
    input  logic [IDX_W-1:0]  in_idx,
    input  point_t            in_point,
    input  point_t            query,
    output tag_t              out_tag,
    output logic [IDX_W-1:0]  out_idx,
    output logic [DIST_W-1:0] out_dist
);

    // Magnitude of the difference of two signed coordinates; it always fits 16 bits.
    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        m = d[COORD_W] ? (COORD_W+1)'(-d) : d;
        return m[MAG_W-1:0];
    endfunction

    tag_t              s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [IDX_W-1:0]  s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [MAG_W-1:0]  mx_reg, my_reg, mz_reg;
    logic [SQ_W-1:0]   sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end else begin
            s1_tag_reg <= in_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_idx_reg <= in_idx;
        mx_reg     <= abs_diff(query.x, in_point.x);
        my_reg     <= abs_diff(query.y, in_point.y);
        mz_reg     <= abs_diff(query.z, in_point.z);

        s2_idx_reg <= s1_idx_reg;
        sx_reg     <= mx_reg * mx_reg;
        sy_reg     <= my_reg * my_reg;
        sz_reg     <= mz_reg * mz_reg;

        s3_idx_reg <= s2_idx_reg;
        sum_reg    <= DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
    end

    assign out_tag  = s3_tag_reg;
    assign out_idx  = s3_idx_reg;
    assign out_dist = sum_reg;

endmodule

// File: src/nearest_point_search_unit.sv
// Channel   Direction  tdata (low bit up)                    tuser
// s_        in         coord_x, coord_y, coord_z (48 bits)   action (2 bits)
// m_        out        nearest_index, distance_sq, 2 zeros   store_empty (1 bit)
//
// A clear or a load completes at its transfer; the unit is ready again on the next cycle.
// A query reads the stored points one at a time: the point memory has
// one read port, and the distance pipeline takes one stored point per cycle.
// A query on an empty store skips the scan and goes straight to the finishing state.
// Reset is synchronous and active low; it empties the store but leaves the memory as is.
// A result that is not yet taken holds the next query in its finishing state until the transfer.
module nearest_point_search_unit import nps_pkg::*; #(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,  // coord_x [15:0], coord_y [31:16], coord_z [47:32]
    input  logic [1:0]    s_tuser,  // action [1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,  // nearest_index [11:0], distance_sq [45:12], zero [47:46]
    output logic          m_tuser   // store_empty [0]
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PAD_W  = 48 - IDX_OUT_W - DIST_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    tag_t                rd_tag_reg, rd_tag_next;
    logic [ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    point_t              query_reg, query_next;
    logic                empty_reg, empty_next;
    logic [DIST_W-1:0]   best_reg, best_next;
    logic [ADDR_W-1:0]   best_idx_reg, best_idx_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [IDX_OUT_W-1:0] m_idx_reg, m_idx_next;
    logic [DIST_W-1:0]   m_dist_reg, m_dist_next;
    logic                m_empty_reg, m_empty_next;

    logic                in_xfer;
    logic                full;
    logic                wr_en;
    logic                rd_en;
    point_t              rd_point;
    tag_t                dist_tag;
    logic [ADDR_W-1:0]   dist_idx;
    logic [DIST_W-1:0]   dist_val;
    logic [ADDR_W+IDX_OUT_W-1:0] best_idx_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(MAX_POINTS));

    // A load writes the next free entry in the cycle of its transfer.
    assign wr_en = in_xfer && (s_tuser == ACT_LOAD) && !full;

    // During a scan one stored point is read per cycle until all have been issued.
    assign rd_en = (state_reg == ST_SCAN) && (issue_reg < count_reg);

    // The reported index is the low bits of the winning entry, zero-extended if narrower.
    assign best_idx_ext = {{IDX_OUT_W{1'b0}}, best_idx_reg};

    nps_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_point)
    );

    nps_dist #(
        .IDX_W (ADDR_W)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (rd_tag_reg),
        .in_idx   (rd_idx_reg),
        .in_point (rd_point),
        .query    (query_reg),
        .out_tag  (dist_tag),
        .out_idx  (dist_idx),
        .out_dist (dist_val)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        query_next    = query_reg;
        empty_next    = empty_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        m_idx_next    = m_idx_reg;
        m_dist_next   = m_dist_reg;
        m_empty_next  = m_empty_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        // The tag is registered alongside the read so that it lines up with the read data.
        rd_tag_next.vld   = rd_en;
        rd_tag_next.first = (issue_reg == '0);
        rd_tag_next.last  = (issue_reg == count_reg - CNT_W'(1));
        rd_idx_next       = issue_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (s_tuser)
                        ACT_CLEAR: begin
                            count_next = '0;
                        end
                        ACT_LOAD: begin
                            if (!full) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_QUERY: begin
                            query_next = s_tdata;
                            issue_next = '0;
                            if (count_reg == '0) begin
                                empty_next = 1'b1;
                                state_next = ST_FINISH;
                            end else begin
                                empty_next = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            // The unused action code is dropped without effect.
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                // Less-or-equal lets a later point at the same distance take over,
                // so the highest index among equal minima wins.
                if (dist_tag.vld) begin
                    if (dist_tag.first || (dist_val <= best_reg)) begin
                        best_next     = dist_val;
                        best_idx_next = dist_idx;
                    end
                    if (dist_tag.last) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_empty_next  = empty_reg;
                    m_idx_next    = empty_reg ? '0 : best_idx_ext[IDX_OUT_W-1:0];
                    m_dist_next   = empty_reg ? '0 : best_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_tag_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rd_tag_reg   <= rd_tag_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rd_idx_reg   <= rd_idx_next;
        query_reg    <= query_next;
        empty_reg    <= empty_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        m_idx_reg    <= m_idx_next;
        m_dist_reg   <= m_dist_next;
        m_empty_reg  <= m_empty_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_dist_reg, m_idx_reg};
    assign m_tuser  = m_empty_reg;

`ifndef SYNTH
    // The fill count never passes the store's depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count exceeds the store depth");

    // Distances come out of the pipeline only while a scan is running.
    a_dist_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_tag.vld |-> (state_reg == ST_SCAN))
        else $error("distance result outside a scan");

    // A query on a non-empty store starts a scan on the next cycle.
    a_query_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_tuser == ACT_QUERY) && (count_reg != '0)) |=> (state_reg == ST_SCAN))
        else $error("query did not start a scan");

    // A result for an empty store carries a zero index and distance.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("empty-store result with nonzero payload");

    // A load into a full store never writes the memory.
    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !full)
        else $error("write into a full store");
`endif

endmodule
